[sv/text_cell_blit_engine_macros.svh]
// assertion macros shared by the text cell blit engine modules
`ifndef TEXT_CELL_BLIT_ENGINE_MACROS_SVH
`define TEXT_CELL_BLIT_ENGINE_MACROS_SVH

`ifndef SYNTH
// checked property, quiet while reset is held
`define TBE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("text cell blit engine assertion failed");
// checked property, also active during reset
`define TBE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("text cell blit engine assertion failed");
`else
`define TBE_ASSERT(label, prop)
`define TBE_ASSERT_ALWAYS(label, prop)
`endif

`endif

[sv/tbe_pkg.sv]
// shared constants, types and tables of the text cell blit engine
package tbe_pkg;

    // screen geometry
    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int CELLS = ROWS * COLS;

    // field widths of the command transaction
    localparam int ROW_W = 5;
    localparam int COL_W = 7;

    // derived widths
    localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PW  = $clog2(CELLS + 1);
    localparam int NRW = $clog2(ROWS + 1);
    localparam int NCW = $clog2(COLS + 1);

    // limits at comparison widths
    localparam logic [ROW_W:0] ROWS_V  = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0] COLS_V  = (COL_W + 1)'(COLS);
    localparam logic [PW-1:0]  CELLS_V = PW'(CELLS);
    localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // command codes on the input channel
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_COPY  = 2'd3;

    // operation codes passed to the back end
    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_COPY   = 3'd3;
    localparam logic [2:0] OP_REJECT = 3'd4;

    // fill values of a cleared cell
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [3:0] BLANK_FG   = 4'd7;

    // colour remap: 0 goes to 15, others step down by one
    localparam logic [3:0] COLOUR_MAP [16] = '{
        4'd15, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
        4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14
    };

    // decoded operation handed from front to back
    typedef struct packed {
        logic [2:0]     op;
        logic [AW-1:0]  src;
        logic [AW-1:0]  dst;
        logic [15:0]    data;
        logic [NRW-1:0] nrows;
        logic [NCW-1:0] ncols;
        logic [NCW-1:0] skip;
        logic           backward;
    } tbe_op_t;

    // linear cell index of a row and column
    function automatic logic [AW-1:0] lin_addr(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
        return AW'(int'(r) * COLS + int'(c));
    endfunction

endpackage

[sv/tbe_if.sv]
// valid/ready channel interfaces for commands and results
interface tbe_req_if
    import tbe_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [ROW_W-1:0] top_row;
    logic [COL_W-1:0] left_col;
    logic [ROW_W-1:0] bottom_row;
    logic [COL_W-1:0] right_col;
    logic [ROW_W-1:0] dest_row;
    logic [COL_W-1:0] dest_col;
    logic [7:0]       char_code;
    logic [3:0]       fg_index;
    logic [3:0]       bg_index;
    logic             continue_run;

    modport source (
        output valid, cmd, top_row, left_col, bottom_row, right_col,
               dest_row, dest_col, char_code, fg_index, bg_index, continue_run,
        input  ready
    );
    modport sink (
        input  valid, cmd, top_row, left_col, bottom_row, right_col,
               dest_row, dest_col, char_code, fg_index, bg_index, continue_run,
        output ready
    );
endinterface

interface tbe_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] read_char;
    logic [7:0] read_attr;

    modport source (output valid, status, read_char, read_attr, input ready);
    modport sink (input valid, status, read_char, read_attr, output ready);
endinterface

[sv/tbe_front.sv]
// front end: accepts commands, checks coordinates, builds back end operations
`include "text_cell_blit_engine_macros.svh"

module tbe_front
    import tbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    tbe_req_if.sink req,
    input  logic    q_ready,
    output logic    q_push,
    output tbe_op_t q_entry
);

    logic             acc;
    logic             row_ok, col_ok, brow_ok, rcol_ok, drow_ok, dcol_ok;
    logic             order_ok, fit_ok, copy_ok;
    logic [ROW_W-1:0] span_r;
    logic [COL_W-1:0] span_c;
    logic [ROW_W:0]   dr_end;
    logic [COL_W:0]   dc_end;
    logic [AW-1:0]    src_base, src_end, dst_base, dst_end;
    logic             w_ok;
    logic [AW-1:0]    w_addr;
    logic [PW-1:0]    wp_reg, wp_next;
    logic [3:0]       bg_map, fg_map;

    assign req.ready = q_ready;
    assign acc       = req.valid && q_ready;
    assign q_push    = acc;

    // range checks on every coordinate
    assign row_ok  = {1'b0, req.top_row} < ROWS_V;
    assign col_ok  = {1'b0, req.left_col} < COLS_V;
    assign brow_ok = {1'b0, req.bottom_row} < ROWS_V;
    assign rcol_ok = {1'b0, req.right_col} < COLS_V;
    assign drow_ok = {1'b0, req.dest_row} < ROWS_V;
    assign dcol_ok = {1'b0, req.dest_col} < COLS_V;

    // rectangle shape and target fit
    assign order_ok = (req.top_row <= req.bottom_row) && (req.left_col <= req.right_col);
    assign span_r   = req.bottom_row - req.top_row;
    assign span_c   = req.right_col - req.left_col;
    assign dr_end   = {1'b0, req.dest_row} + {1'b0, span_r};
    assign dc_end   = {1'b0, req.dest_col} + {1'b0, span_c};
    assign fit_ok   = (dr_end < ROWS_V) && (dc_end < COLS_V);
    assign copy_ok  = row_ok && col_ok && brow_ok && rcol_ok && drow_ok && dcol_ok
                      && order_ok && fit_ok;

    // linear corner addresses
    assign src_base = lin_addr(req.top_row, req.left_col);
    assign src_end  = lin_addr(req.bottom_row, req.right_col);
    assign dst_base = lin_addr(req.dest_row, req.dest_col);
    assign dst_end  = lin_addr(dr_end[ROW_W-1:0], dc_end[COL_W-1:0]);

    // write target: cell after the last write, or row and column
    assign w_ok   = req.continue_run ? (wp_reg < CELLS_V) : (row_ok && col_ok);
    assign w_addr = req.continue_run ? wp_reg[AW-1:0] : src_base;

    assign bg_map = COLOUR_MAP[req.bg_index];
    assign fg_map = COLOUR_MAP[req.fg_index];

    // operation decode
    always_comb
    begin
        q_entry          = '0;
        q_entry.op       = OP_REJECT;
        q_entry.src      = src_base;
        q_entry.dst      = dst_base;
        q_entry.data     = {bg_map, fg_map, req.char_code};
        q_entry.nrows    = NRW'({1'b0, span_r} + (ROW_W + 1)'(1));
        q_entry.ncols    = NCW'({1'b0, span_c} + (COL_W + 1)'(1));
        q_entry.skip     = NCW'(COLS - int'(span_c));
        q_entry.backward = 1'b0;
        unique case (req.cmd)
            CMD_READ:
            begin
                q_entry.op = row_ok && col_ok ? OP_READ : OP_REJECT;
            end
            CMD_WRITE:
            begin
                q_entry.op  = w_ok ? OP_WRITE : OP_REJECT;
                q_entry.src = w_addr;
            end
            CMD_CLEAR:
            begin
                q_entry.op   = OP_CLEAR;
                q_entry.data = {bg_map, BLANK_FG, SPACE_CHAR};
            end
            CMD_COPY:
            begin
                q_entry.op = copy_ok ? OP_COPY : OP_REJECT;
                // target above the source in memory order runs backward
                if (dst_base > src_base)
                begin
                    q_entry.backward = 1'b1;
                    q_entry.src      = src_end;
                    q_entry.dst      = dst_end;
                end
            end
            default:
            begin
                q_entry.op = OP_REJECT;
            end
        endcase
    end

    // write pointer follows each accepted write that is in range
    always_comb
    begin
        wp_next = wp_reg;
        if (acc && (req.cmd == CMD_WRITE) && w_ok)
        begin
            wp_next = PW'(w_addr) + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
        end
    end

    // pointer never runs past one beyond the last cell
    `TBE_ASSERT_ALWAYS(a_wp_range, wp_reg <= CELLS_V)

endmodule

[sv/tbe_queue.sv]
// short operation queue between front and back ends
`include "text_cell_blit_engine_macros.svh"

module tbe_queue
    import tbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  tbe_op_t push_op,
    output logic    ready,
    output logic    valid,
    output tbe_op_t head,
    input  logic    pop
);

    tbe_op_t        slot_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QCW-1:0] count_reg, count_next;

    assign ready = count_reg != QCW'(QDEPTH);
    assign valid = count_reg != '0;
    assign head  = slot_reg[rd_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == QAW'(QDEPTH - 1)) ? '0 : rd_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_op;
        end
    end

    `TBE_ASSERT(a_no_overflow, push |-> count_reg < QCW'(QDEPTH))
    `TBE_ASSERT(a_no_underflow, pop |-> count_reg != '0)

endmodule

[sv/tbe_back.sv]
// back end: cell store and the sequencer that runs each operation
`include "text_cell_blit_engine_macros.svh"

module tbe_back
    import tbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  tbe_op_t   q_head,
    output logic      q_pop,
    tbe_rsp_if.source rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDATA = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_CRD   = 3'd3;
    localparam logic [2:0] S_CWR   = 3'd4;

    logic [2:0]     state_reg, state_next;
    tbe_op_t        cur_reg, cur_next;
    logic [AW-1:0]  src_reg, src_next;
    logic [AW-1:0]  dst_reg, dst_next;
    logic [NCW-1:0] col_reg, col_next;
    logic [NRW-1:0] row_reg, row_next;
    logic [AW-1:0]  clr_reg, clr_next;

    logic [15:0]    mem [CELLS];
    logic [15:0]    mem_rdata_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [15:0]    mem_wdata;

    logic           out_valid_reg, out_valid_next;
    logic           out_status_reg;
    logic [7:0]     out_char_reg, out_attr_reg;
    logic           out_free, ld_out;
    logic           res_status;
    logic [7:0]     res_char, res_attr;

    logic           last_col, last_row;
    logic [AW-1:0]  step;

    assign out_free      = !out_valid_reg || rsp.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.read_char = out_char_reg;
    assign rsp.read_attr = out_attr_reg;

    // copy walk position
    assign last_col = (col_reg + NCW'(1)) == cur_reg.ncols;
    assign last_row = (row_reg + NRW'(1)) == cur_reg.nrows;
    assign step     = last_col ? AW'(cur_reg.skip) : AW'(1);

    // operation sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_addr   = src_reg;
        mem_wdata  = cur_reg.data;
        q_pop      = 1'b0;
        ld_out     = 1'b0;
        res_status = 1'b0;
        res_char   = '0;
        res_attr   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    unique case (q_head.op)
                        OP_READ:
                        begin
                            mem_addr   = q_head.src;
                            state_next = S_RDATA;
                        end
                        OP_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = q_head.src;
                            mem_wdata = q_head.data;
                            ld_out    = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_COPY:
                        begin
                            src_next   = q_head.src;
                            dst_next   = q_head.dst;
                            col_next   = '0;
                            row_next   = '0;
                            state_next = S_CRD;
                        end
                        default:
                        begin
                            ld_out     = 1'b1;
                            res_status = 1'b1;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                ld_out     = 1'b1;
                res_char   = mem_rdata_reg[7:0];
                res_attr   = mem_rdata_reg[15:8];
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                if (clr_reg == LAST_CELL)
                begin
                    ld_out     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_CRD:
            begin
                mem_addr   = src_reg;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                mem_we    = 1'b1;
                mem_addr  = dst_reg;
                mem_wdata = mem_rdata_reg;
                if (last_col && last_row)
                begin
                    ld_out     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    src_next   = cur_reg.backward ? src_reg - step : src_reg + step;
                    dst_next   = cur_reg.backward ? dst_reg - step : dst_reg + step;
                    col_next   = last_col ? '0 : col_reg + NCW'(1);
                    row_next   = last_col ? row_reg + NRW'(1) : row_reg;
                    state_next = S_CRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ld_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // operation context and result payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        col_reg <= col_next;
        row_reg <= row_next;
        clr_reg <= clr_next;
        if (ld_out)
        begin
            out_status_reg <= res_status;
            out_char_reg   <= res_char;
            out_attr_reg   <= res_attr;
        end
    end

    // single port cell store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    `TBE_ASSERT(a_out_no_overwrite, ld_out |-> out_free)
    `TBE_ASSERT(a_copy_col_range, (state_reg == S_CWR) |-> (col_reg < cur_reg.ncols))
    `TBE_ASSERT(a_read_result, (state_reg == S_RDATA) |=> out_valid_reg)

endmodule

[sv/text_cell_blit_engine.sv]
// Results are registered: a write or rejected command loads its result as the
// sequencer takes it, a read after read data, clear and copy after the last cell.
// Throughput: one write or rejected command per cycle while results are taken;
// clear and copy are bounded by the single port of the cell store, a copy reading
// then writing each cell; a 2-entry queue takes commands while the back end works.
// Active-low async reset clears queue, sequencer, write pointer, not cell store.
module text_cell_blit_engine
    import tbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tbe_req_if.sink   req,
    tbe_rsp_if.source rsp
);

    logic    q_push, q_ready, q_valid, q_pop;
    tbe_op_t q_entry, q_head;

    // command decode and write pointer
    tbe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    // decoupling queue
    tbe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_entry),
        .ready   (q_ready),
        .valid   (q_valid),
        .head    (q_head),
        .pop     (q_pop)
    );

    // cell store and sequencer
    tbe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

[bench/tb.sv]
// testbench of the text cell blit engine: command traffic checked against a screen model
module tb;
    import tbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // no transaction for this many cycles ends the run
    localparam int QUIET_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 300;

    typedef struct {
        logic [1:0]       cmd;
        logic [ROW_W-1:0] top_row;
        logic [COL_W-1:0] left_col;
        logic [ROW_W-1:0] bottom_row;
        logic [COL_W-1:0] right_col;
        logic [ROW_W-1:0] dest_row;
        logic [COL_W-1:0] dest_col;
        logic [7:0]       char_code;
        logic [3:0]       fg_index;
        logic [3:0]       bg_index;
        logic             continue_run;
    } blit_cmd_t;

    typedef struct {
        logic       status;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } blit_result_t;

    logic clk;
    logic rst_n;

    tbe_req_if req_ch ();
    tbe_rsp_if rsp_ch ();

    text_cell_blit_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // screen model and write pointer
    logic [15:0]  screen      [CELLS];
    logic [15:0]  screen_snap [CELLS];
    int           next_cell;
    blit_result_t pending_results [$];
    blit_result_t oldest_result;

    int errors;
    int items_sent;
    int quiet_cycles;
    int burst_left;
    bit sender_gaps;
    int stall_mode;
    int stall_mode_cycles;
    int stall_hold;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // color index remap: 0 wraps to 15, others step down
    function automatic logic [3:0] remap_colour(input logic [3:0] n);
        return (n == 4'd0) ? 4'd15 : n - 4'd1;
    endfunction

    // apply one command to the screen model and return its result
    function automatic blit_result_t predict_blit(input blit_cmd_t c);
        blit_result_t res;
        int idx;
        int nrows;
        int ncols;
        res = '{status: 1'b0, read_char: 8'h00, read_attr: 8'h00};
        case (c.cmd)
            CMD_READ:
            begin
                if (c.top_row >= ROWS || c.left_col >= COLS)
                    res.status = 1'b1;
                else
                begin
                    idx = int'(c.top_row) * COLS + int'(c.left_col);
                    res.read_char = screen[idx][7:0];
                    res.read_attr = screen[idx][15:8];
                end
            end
            CMD_WRITE:
            begin
                if (c.continue_run)
                    idx = next_cell;
                else if (c.top_row >= ROWS || c.left_col >= COLS)
                    idx = CELLS;
                else
                    idx = int'(c.top_row) * COLS + int'(c.left_col);
                if (idx >= CELLS)
                    res.status = 1'b1;
                else
                begin
                    screen[idx] = {remap_colour(c.bg_index), remap_colour(c.fg_index),
                                   c.char_code};
                    next_cell = idx + 1;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = {remap_colour(c.bg_index), BLANK_FG, SPACE_CHAR};
            end
            CMD_COPY:
            begin
                if (c.top_row >= ROWS || c.bottom_row >= ROWS || c.dest_row >= ROWS ||
                    c.left_col >= COLS || c.right_col >= COLS || c.dest_col >= COLS ||
                    c.top_row > c.bottom_row || c.left_col > c.right_col)
                    res.status = 1'b1;
                else
                begin
                    nrows = int'(c.bottom_row) - int'(c.top_row) + 1;
                    ncols = int'(c.right_col) - int'(c.left_col) + 1;
                    if (int'(c.dest_row) + nrows > ROWS || int'(c.dest_col) + ncols > COLS)
                        res.status = 1'b1;
                    else
                    begin
                        // copy from a snapshot so overlap never matters
                        screen_snap = screen;
                        for (int r = 0; r < nrows; r++)
                            for (int k = 0; k < ncols; k++)
                                screen[(int'(c.dest_row) + r) * COLS + int'(c.dest_col) + k] =
                                    screen_snap[(int'(c.top_row) + r) * COLS +
                                                int'(c.left_col) + k];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // command of the given op with every other field random
    function automatic blit_cmd_t random_cmd(input logic [1:0] op);
        blit_cmd_t c;
        c.cmd          = op;
        c.top_row      = ROW_W'($urandom);
        c.left_col     = COL_W'($urandom);
        c.bottom_row   = ROW_W'($urandom);
        c.right_col    = COL_W'($urandom);
        c.dest_row     = ROW_W'($urandom);
        c.dest_col     = COL_W'($urandom);
        c.char_code    = 8'($urandom);
        c.fg_index     = 4'($urandom);
        c.bg_index     = 4'($urandom);
        c.continue_run = 1'($urandom);
        return c;
    endfunction

    function automatic blit_cmd_t write_cmd(input int row, input int col, input int ch,
                                            input int fg, input int bg);
        blit_cmd_t c;
        c = random_cmd(CMD_WRITE);
        c.top_row      = ROW_W'(row);
        c.left_col     = COL_W'(col);
        c.char_code    = 8'(ch);
        c.fg_index     = 4'(fg);
        c.bg_index     = 4'(bg);
        c.continue_run = 1'b0;
        return c;
    endfunction

    function automatic blit_cmd_t copy_cmd(input int sr, input int sc, input int er,
                                           input int ec, input int tr, input int tc);
        blit_cmd_t c;
        c = random_cmd(CMD_COPY);
        c.top_row    = ROW_W'(sr);
        c.left_col   = COL_W'(sc);
        c.bottom_row = ROW_W'(er);
        c.right_col  = COL_W'(ec);
        c.dest_row   = ROW_W'(tr);
        c.dest_col   = COL_W'(tc);
        return c;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // drive one command transaction, with burst gaps, and record its expected result
    task automatic send_cmd(input blit_cmd_t c);
        int gap;
        @(negedge clk);
        if (sender_gaps && burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= c.cmd;
        req_ch.top_row      <= c.top_row;
        req_ch.left_col     <= c.left_col;
        req_ch.bottom_row   <= c.bottom_row;
        req_ch.right_col    <= c.right_col;
        req_ch.dest_row     <= c.dest_row;
        req_ch.dest_col     <= c.dest_col;
        req_ch.char_code    <= c.char_code;
        req_ch.fg_index     <= c.fg_index;
        req_ch.bg_index     <= c.bg_index;
        req_ch.continue_run <= c.continue_run;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_blit(c));
        items_sent++;
        burst_left--;
    endtask

    task automatic read_cell(input int idx);
        blit_cmd_t c;
        c = random_cmd(CMD_READ);
        c.top_row  = ROW_W'(idx / COLS);
        c.left_col = COL_W'(idx % COLS);
        send_cmd(c);
    endtask

    // writes, continued runs, reads and out-of-range coordinates
    task automatic test_write_and_read();
        blit_cmd_t c;
        // continued write right after reset lands on cell zero
        c = random_cmd(CMD_WRITE);
        c.char_code    = 8'h00;
        c.fg_index     = 4'd15;
        c.bg_index     = 4'd0;
        c.continue_run = 1'b1;
        send_cmd(c);
        c = random_cmd(CMD_WRITE);
        c.continue_run = 1'b1;
        send_cmd(c);
        read_cell(0);
        read_cell(1);
        // last cell, then a continued write past the end
        send_cmd(write_cmd(ROWS - 1, COLS - 1, 8'hff, 0, 15));
        c = random_cmd(CMD_WRITE);
        c.continue_run = 1'b1;
        send_cmd(c);
        read_cell(CELLS - 1);
        // coordinates off the screen
        send_cmd(write_cmd(ROWS, 0, 8'h41, 3, 4));
        send_cmd(write_cmd((1 << ROW_W) - 1, (1 << COL_W) - 1, 8'h42, 5, 6));
        c = random_cmd(CMD_READ);
        c.top_row  = ROW_W'(ROWS);
        c.left_col = COL_W'((1 << COL_W) - 1);
        send_cmd(c);
    endtask

    // clear fills the screen and keeps the write pointer
    task automatic test_clear_screen();
        blit_cmd_t c;
        c = random_cmd(CMD_CLEAR);
        c.bg_index = 4'd0;
        send_cmd(c);
        read_cell(12 * COLS + 40);
        read_cell(CELLS - 1);
        c = random_cmd(CMD_WRITE);
        c.continue_run = 1'b1;
        send_cmd(c);
    endtask

    // overlapping copies both ways, rejected rectangles, extreme sizes
    task automatic test_copy_rectangle();
        blit_cmd_t c;
        send_cmd(write_cmd(2, 10, 8'h61, 1, 2));
        c = random_cmd(CMD_WRITE);
        c.continue_run = 1'b1;
        send_cmd(c);
        c = random_cmd(CMD_WRITE);
        c.continue_run = 1'b1;
        send_cmd(c);
        // target below the source, then above it
        send_cmd(copy_cmd(2, 10, 3, 13, 3, 11));
        send_cmd(copy_cmd(3, 11, 4, 14, 2, 10));
        read_cell(3 * COLS + 11);
        read_cell(2 * COLS + 10);
        // top below bottom, left right of right, target past edge, row off screen
        send_cmd(copy_cmd(5, 0, 4, 3, 0, 0));
        send_cmd(copy_cmd(0, 9, 1, 8, 0, 0));
        send_cmd(copy_cmd(0, 0, 2, 2, ROWS - 2, 0));
        send_cmd(copy_cmd(0, 0, ROWS, 0, 0, 0));
        // single cell into the far corner, then the whole screen onto itself
        send_cmd(copy_cmd(0, 0, 0, 0, ROWS - 1, COLS - 1));
        send_cmd(copy_cmd(0, 0, ROWS - 1, COLS - 1, 0, 0));
    endtask

    // positioned write followed by a continued run, then read-back
    task automatic random_write_run();
        blit_cmd_t c;
        int len;
        int first;
        c = random_cmd(CMD_WRITE);
        c.continue_run = 1'b0;
        if ($urandom_range(0, 6) == 0)
        begin
            c.top_row  = ROW_W'(ROWS - 1);
            c.left_col = COL_W'($urandom_range(COLS - 8, COLS - 1));
        end
        else
        begin
            c.top_row  = ROW_W'($urandom_range(0, ROWS - 1));
            c.left_col = COL_W'($urandom_range(0, COLS - 1));
        end
        first = int'(c.top_row) * COLS + int'(c.left_col);
        send_cmd(c);
        len = $urandom_range(1, 10);
        repeat (len)
        begin
            c = random_cmd(CMD_WRITE);
            c.continue_run = 1'b1;
            send_cmd(c);
        end
        repeat ($urandom_range(1, 3))
            read_cell(clamp(first + $urandom_range(0, len), 0, CELLS - 1));
    endtask

    // mostly small rectangles near the source, a few large ones
    task automatic random_copy();
        int nr;
        int nc;
        int sr;
        int sc;
        int tr;
        int tc;
        if ($urandom_range(0, 19) == 0)
        begin
            nr = $urandom_range(1, ROWS);
            nc = $urandom_range(1, COLS);
        end
        else
        begin
            nr = $urandom_range(1, 4);
            nc = $urandom_range(1, 8);
        end
        sr = $urandom_range(0, ROWS - nr);
        sc = $urandom_range(0, COLS - nc);
        if ($urandom_range(0, 1) == 1)
        begin
            tr = clamp(sr + $urandom_range(0, 4) - 2, 0, ROWS - nr);
            tc = clamp(sc + $urandom_range(0, 6) - 3, 0, COLS - nc);
        end
        else
        begin
            tr = $urandom_range(0, ROWS - nr);
            tc = $urandom_range(0, COLS - nc);
        end
        // sometimes push the target past the right edge
        if ($urandom_range(0, 9) == 0)
            tc = clamp(COLS - nc + $urandom_range(1, nc), 0, COLS - 1);
        send_cmd(copy_cmd(sr, sc, sr + nr - 1, sc + nc - 1, tr, tc));
        read_cell(tr * COLS + tc);
    endtask

    // random mix of runs, reads, copies, clears and unconstrained commands
    task automatic test_random_traffic();
        int stop_at;
        int pick;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 19) == 0)
                sender_gaps = !sender_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                random_write_run();
            else if (pick < 55)
                repeat ($urandom_range(1, 4))
                    read_cell($urandom_range(0, CELLS - 1));
            else if (pick < 75)
                random_copy();
            else if (pick < 77)
                send_cmd(random_cmd(CMD_CLEAR));
            else
                send_cmd(random_cmd(2'($urandom)));
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d char %h attr %h", $realtime,
                         rsp_ch.status, rsp_ch.read_char, rsp_ch.read_attr);
                errors++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp_ch.status !== oldest_result.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d", $realtime,
                             oldest_result.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.read_char !== oldest_result.read_char)
                begin
                    $display("%0t: read_char mismatch, expected %h, actual %h", $realtime,
                             oldest_result.read_char, rsp_ch.read_char);
                    errors++;
                end
                if (rsp_ch.read_attr !== oldest_result.read_attr)
                begin
                    $display("%0t: read_attr mismatch, expected %h, actual %h", $realtime,
                             oldest_result.read_attr, rsp_ch.read_attr);
                    errors++;
                end
            end
        end
    end

    // result side stalls in one of three randomly chosen patterns: always ready, random, or held low
    always @(negedge clk)
    begin
        if (stall_mode_cycles == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_mode_cycles = $urandom_range(50, 300);
        end
        else
            stall_mode_cycles--;
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    rsp_ch.ready <= 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_hold = $urandom_range(1, 16);
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= 1'b1;
            end
        endcase
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        items_sent = 0;
        quiet_cycles = 0;
        burst_left = 0;
        sender_gaps = 1'b1;
        stall_mode = 0;
        stall_mode_cycles = 0;
        stall_hold = 0;
        next_cell = 0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_READ;
        req_ch.top_row = '0;
        req_ch.left_col = '0;
        req_ch.bottom_row = '0;
        req_ch.right_col = '0;
        req_ch.dest_row = '0;
        req_ch.dest_col = '0;
        req_ch.char_code = '0;
        req_ch.fg_index = '0;
        req_ch.bg_index = '0;
        req_ch.continue_run = 1'b0;
        rsp_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_write_and_read();
        test_clear_screen();
        test_copy_rectangle();
        test_random_traffic();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/tbe_pkg.sv
sv/tbe_if.sv
sv/tbe_front.sv
sv/tbe_queue.sv
sv/tbe_back.sv
sv/text_cell_blit_engine.sv
bench/tb.sv
